### design/sound_fifo_psg_mixer_top_defines.svh
// Assertion helpers for the checker file of the sound mixer.
`ifndef SOUND_FIFO_PSG_MIXER_TOP_DEFINES_SVH
`define SOUND_FIFO_PSG_MIXER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sfpm_pkg.sv
package sfpm_pkg;

  localparam int unsigned FifoDepthDef    = 32;
  localparam int unsigned SamplePeriodDef = 512;
  localparam int unsigned MaxSamples      = 8;
  localparam int unsigned ReqLevel        = 16;

  localparam logic [2:0] ModeTick    = 3'd0;
  localparam logic [2:0] ModeByteWr  = 3'd1;
  localparam logic [2:0] ModeHalfWr  = 3'd2;
  localparam logic [2:0] ModeHalfRd  = 3'd3;
  localparam logic [2:0] ModeDmaWord = 3'd4;

  localparam logic [7:0] RegSq0Duty = 8'h60;
  localparam logic [7:0] RegSq0Vol  = 8'h62;
  localparam logic [7:0] RegSq0Freq = 8'h64;
  localparam logic [7:0] RegSq1Ctl  = 8'h68;
  localparam logic [7:0] RegSq1Freq = 8'h6C;
  localparam logic [7:0] RegNzVol   = 8'h78;
  localparam logic [7:0] RegNzCtl   = 8'h7C;
  localparam logic [7:0] RegPsgCtl  = 8'h80;
  localparam logic [7:0] RegMixCtl  = 8'h82;
  localparam logic [7:0] RegEnable  = 8'h84;
  localparam logic [7:0] RegBias    = 8'h88;
  localparam logic [7:0] RegFifoLo  = 8'hA0;
  localparam logic [7:0] RegFifoHi  = 8'hAF;

  typedef enum logic [2:0] {
    OpNop,
    OpTick,
    OpPush,
    OpReg,
    OpRead
  } sfpm_op_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  offset;
    logic [31:0] write_data;
    logic        fifo_select;
    logic [11:0] cycles;
    logic [1:0]  timer_overflow;
  } sfpm_in_t;

  typedef struct packed {
    logic [15:0]        read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               sample_valid;
    logic               dma_request_a;
    logic               dma_request_b;
    logic               last;
  } sfpm_out_t;

  typedef struct packed {
    sfpm_op_e    op;
    logic        fifo;
    logic [2:0]  nbytes;
    logic        check;
    logic [7:0]  offset;
    logic [31:0] data;
    logic [11:0] cycles;
    logic [1:0]  ovf;
  } sfpm_cmd_t;

  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] phase);
    logic [7:0] wave;
    case (duty)
      2'd0:    wave = 8'b1000_0000;
      2'd1:    wave = 8'b1000_0001;
      2'd2:    wave = 8'b1110_0001;
      default: wave = 8'b0111_1110;
    endcase
    return wave[phase];
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] s, input logic short_mode);
    logic        x;
    logic [15:0] n;
    x = s[0] ^ s[1];
    n = {1'b0, x, s[14:1]};
    if (short_mode) begin
      n[6] = x;
    end
    return n;
  endfunction

endpackage

### design/sound_fifo_psg_mixer_top.sv
// Sound unit with two signed 8-bit PCM FIFOs, two square channels and a
// noise channel. Input items (ticks, register writes, halfword reads, DMA
// word appends) arrive on the in channel; result items leave on the out
// channel. Both channels move a transfer when valid is high and stall low.
// Each item yields zero to eight sample results followed by one status
// result marked by last, carrying read data and the DMA refill requests.
// A two-entry queue decodes items ahead of the execution sequencer, and
// the result register lets the sequencer finish a step while the receiver
// holds the previous result.
// Steps: register writes and reads pass through an execute step before the
// status result, ignored items go straight to it, and a FIFO push writes its
// bytes one after another. A tick runs the serial divider of each running
// square channel, steps the noise LFSR once per elapsed noise period, then
// pops or clears each FIFO whose selected timer overflowed and emits its samples.
// Items run one at a time: the next queued item starts the cycle after the
// previous status result is registered.
// While out_stall_i is high the sequencer holds before its next result and
// the input queue fills, then raises in_stall_o.
// Reset returns the control and channel registers to their initial values, empties both FIFOs and drops queued items.
module sound_fifo_psg_mixer_top #(
  parameter int unsigned FIFO_DEPTH    = sfpm_pkg::FifoDepthDef,
  parameter int unsigned SAMPLE_PERIOD = sfpm_pkg::SamplePeriodDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfpm_pkg::sfpm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfpm_pkg::sfpm_out_t out_data_o
);
  import sfpm_pkg::*;

  logic      cmd_valid;
  logic      cmd_take;
  sfpm_cmd_t cmd;

  sfpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  sfpm_back #(
    .FIFO_DEPTH    (FIFO_DEPTH),
    .SAMPLE_PERIOD (SAMPLE_PERIOD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/sfpm_front.sv
module sfpm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sfpm_pkg::sfpm_in_t  in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_take_i,
  output sfpm_pkg::sfpm_cmd_t cmd_o
);
  import sfpm_pkg::*;

  sfpm_cmd_t  cls;
  logic       in_window;
  sfpm_cmd_t  queue_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_window = (in_data_i.offset >= RegFifoLo) && (in_data_i.offset <= RegFifoHi);

  always_comb begin
    cls.op     = OpNop;
    cls.fifo   = in_data_i.offset[2];
    cls.nbytes = 3'd1;
    cls.check  = 1'b1;
    cls.offset = in_data_i.offset;
    cls.data   = in_data_i.write_data;
    cls.cycles = in_data_i.cycles;
    cls.ovf    = in_data_i.timer_overflow;
    case (in_data_i.mode)
      ModeTick: begin
        cls.op = OpTick;
      end
      ModeByteWr: begin
        if (in_window) begin
          cls.op = OpPush;
        end
      end
      ModeHalfWr: begin
        if (in_window) begin
          cls.op     = OpPush;
          cls.nbytes = 3'd2;
        end else begin
          cls.op = OpReg;
        end
      end
      ModeHalfRd: begin
        cls.op = OpRead;
      end
      ModeDmaWord: begin
        cls.op     = OpPush;
        cls.fifo   = in_data_i.fifo_select;
        cls.nbytes = 3'd4;
        cls.check  = 1'b0;
      end
      default: begin
        cls.op = OpNop;
      end
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_valid_o && cmd_take_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

endmodule

### design/sfpm_back.sv
module sfpm_back #(
  parameter int unsigned FIFO_DEPTH    = sfpm_pkg::FifoDepthDef,
  parameter int unsigned SAMPLE_PERIOD = sfpm_pkg::SamplePeriodDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_take_o,
  input  sfpm_pkg::sfpm_cmd_t cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sfpm_pkg::sfpm_out_t out_data_o
);
  import sfpm_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned LW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SW = PW + 1;
  localparam int unsigned MemDepth = 2 ** (PW + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_PUSH     = 4'd2;
  localparam logic [3:0] S_SQ_INIT  = 4'd3;
  localparam logic [3:0] S_SQ_DIV   = 4'd4;
  localparam logic [3:0] S_NZ_ADD   = 4'd5;
  localparam logic [3:0] S_NZ_LOOP  = 4'd6;
  localparam logic [3:0] S_POP_REQ  = 4'd7;
  localparam logic [3:0] S_POP_DATA = 4'd8;
  localparam logic [3:0] S_SAMP     = 4'd9;
  localparam logic [3:0] S_STATUS   = 4'd10;

  logic [3:0]  state_q, state_d;
  sfpm_cmd_t   cmd_q, cmd_d;
  logic [1:0]  req_q, req_d;
  logic [15:0] rd_q, rd_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic        ch_q, ch_d;
  logic [3:0]  step_q, step_d;
  logic [12:0] dvd_q, dvd_d;
  logic [11:0] rem_q, rem_d;
  logic [2:0]  quo_q, quo_d;
  logic [3:0]  nsamp_q, nsamp_d;

  logic [LW-1:0] level_q [2];
  logic [LW-1:0] level_d [2];
  logic [PW-1:0] rptr_q [2];
  logic [PW-1:0] rptr_d [2];
  logic [7:0]    cur_q [2];
  logic [7:0]    cur_d [2];
  logic [1:0]    hold_q, hold_d;
  logic [15:0]   psg_q, psg_d, mix_q, mix_d, bias_q, bias_d;
  logic          en_q, en_d;
  logic [1:0]    sq_duty_q [2];
  logic [1:0]    sq_duty_d [2];
  logic [11:0]   sq_per_q [2];
  logic [11:0]   sq_per_d [2];
  logic [11:0]   sq_tmr_q [2];
  logic [11:0]   sq_tmr_d [2];
  logic [2:0]    sq_ph_q [2];
  logic [2:0]    sq_ph_d [2];
  logic [1:0]    sq_run_q, sq_run_d;
  logic [3:0]    sq_svol_q [2];
  logic [3:0]    sq_svol_d [2];
  logic [3:0]    sq_vol_q [2];
  logic [3:0]    sq_vol_d [2];
  logic [3:0]    nz_svol_q, nz_svol_d, nz_vol_q, nz_vol_d;
  logic          nz_run_q, nz_run_d, nz_short_q, nz_short_d;
  logic [22:0]   nz_per_q, nz_per_d, nz_tmr_q, nz_tmr_d;
  logic [15:0]   nz_sr_q, nz_sr_d;
  logic [31:0]   acc_q, acc_d;

  logic [7:0]  mem [MemDepth];
  logic [7:0]  rdata_q;
  logic        mem_we, mem_re;
  logic [PW:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata;

  logic        out_valid_q, out_valid_d;
  sfpm_out_t   out_q, out_d;
  logic        emit_ok;

  // Sample mixer, evaluated on the current channel state.
  logic [1:0]         sq_on;
  logic               nz_on;
  logic [5:0]         pl, pr, pl_f, pr_f;
  logic [9:0]         pl_m, pr_m;
  logic signed [19:0] fs [2];
  logic signed [19:0] l_sum, r_sum;
  logic signed [15:0] l_sat, r_sat;

  // Per-step helpers.
  logic [SW-1:0] wsum;
  logic [PW-1:0] wptr;
  logic [LW-1:0] lvl_new;
  logic [7:0]    push_byte;
  logic [12:0]   div_r, div_n;
  logic          div_ge;
  logic          pop_en;
  logic [15:0]   v;
  logic [3:0]    nz_ratio, nz_shift;
  logic [22:0]   nz_base;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sq_on[i] = sq_run_q[i] && duty_bit(sq_duty_q[i], sq_ph_q[i]);
    end
    nz_on = nz_run_q && !nz_sr_q[0];
    pr = ((sq_on[0] && psg_q[8]) ? {2'b0, sq_vol_q[0]} : 6'd0)
       + ((sq_on[1] && psg_q[9]) ? {2'b0, sq_vol_q[1]} : 6'd0)
       + ((nz_on && psg_q[11]) ? {2'b0, nz_vol_q} : 6'd0);
    pl = ((sq_on[0] && psg_q[12]) ? {2'b0, sq_vol_q[0]} : 6'd0)
       + ((sq_on[1] && psg_q[13]) ? {2'b0, sq_vol_q[1]} : 6'd0)
       + ((nz_on && psg_q[15]) ? {2'b0, nz_vol_q} : 6'd0);
    pl_m = pl * ({1'b0, psg_q[6:4]} + 4'd1);
    pr_m = pr * ({1'b0, psg_q[2:0]} + 4'd1);
    pl_f = pl_m[8:3];
    pr_f = pr_m[8:3];
    if (mix_q[1:0] == 2'd0) begin
      pl_f = pl_f >> 2;
      pr_f = pr_f >> 2;
    end else if (mix_q[1:0] == 2'd1) begin
      pl_f = pl_f >> 1;
      pr_f = pr_f >> 1;
    end
    if (!en_q) begin
      pl_f = 6'd0;
      pr_f = 6'd0;
    end
    fs[0] = hold_q[0] ? (mix_q[2] ? (20'($signed(cur_q[0])) <<< 8)
                                  : (20'($signed(cur_q[0])) <<< 7)) : 20'sd0;
    fs[1] = hold_q[1] ? (mix_q[3] ? (20'($signed(cur_q[1])) <<< 8)
                                  : (20'($signed(cur_q[1])) <<< 7)) : 20'sd0;
    l_sum = $signed({4'b0, pl_f, 10'b0})
          + (mix_q[9] ? fs[0] : 20'sd0) + (mix_q[13] ? fs[1] : 20'sd0);
    r_sum = $signed({4'b0, pr_f, 10'b0})
          + (mix_q[8] ? fs[0] : 20'sd0) + (mix_q[12] ? fs[1] : 20'sd0);
    if (l_sum > 20'sd32767) begin
      l_sat = 16'sh7FFF;
    end else if (l_sum < -20'sd32768) begin
      l_sat = -16'sh8000;
    end else begin
      l_sat = l_sum[15:0];
    end
    if (r_sum > 20'sd32767) begin
      r_sat = 16'sh7FFF;
    end else if (r_sum < -20'sd32768) begin
      r_sat = -16'sh8000;
    end else begin
      r_sat = r_sum[15:0];
    end
  end

  assign emit_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    req_d      = req_q;
    rd_d       = rd_q;
    byte_idx_d = byte_idx_q;
    ch_d       = ch_q;
    step_d     = step_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    nsamp_d    = nsamp_q;
    level_d    = level_q;
    rptr_d     = rptr_q;
    cur_d      = cur_q;
    hold_d     = hold_q;
    psg_d      = psg_q;
    mix_d      = mix_q;
    bias_d     = bias_q;
    en_d       = en_q;
    sq_duty_d  = sq_duty_q;
    sq_per_d   = sq_per_q;
    sq_tmr_d   = sq_tmr_q;
    sq_ph_d    = sq_ph_q;
    sq_run_d   = sq_run_q;
    sq_svol_d  = sq_svol_q;
    sq_vol_d   = sq_vol_q;
    nz_svol_d  = nz_svol_q;
    nz_vol_d   = nz_vol_q;
    nz_run_d   = nz_run_q;
    nz_short_d = nz_short_q;
    nz_per_d   = nz_per_q;
    nz_tmr_d   = nz_tmr_q;
    nz_sr_d    = nz_sr_q;
    acc_d      = acc_q;
    cmd_take_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    v         = cmd_q.data[15:0];
    wsum      = SW'(rptr_q[cmd_q.fifo]) + SW'(level_q[cmd_q.fifo]);
    if (wsum >= SW'(FIFO_DEPTH)) begin
      wsum = wsum - SW'(FIFO_DEPTH);
    end
    wptr      = wsum[PW-1:0];
    push_byte = cmd_q.data[byte_idx_q*8 +: 8];
    mem_waddr = {cmd_q.fifo, wptr};
    mem_wdata = push_byte;
    mem_raddr = {ch_q, rptr_q[ch_q]};
    lvl_new   = level_q[cmd_q.fifo];
    div_r     = {rem_q, dvd_q[12]};
    div_ge    = div_r >= {1'b0, sq_per_q[ch_q]};
    div_n     = div_ge ? (div_r - {1'b0, sq_per_q[ch_q]}) : div_r;
    pop_en    = cmd_q.ovf[ch_q ? mix_q[14] : mix_q[10]];
    nz_ratio  = {1'b0, v[2:0]} + 4'd1;
    nz_shift  = (v[7:4] > 4'd14) ? 4'd14 : v[7:4];
    nz_base   = {14'd0, nz_ratio, 5'd0};

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          cmd_d      = cmd_i;
          req_d      = 2'b00;
          rd_d       = 16'd0;
          byte_idx_d = 2'd0;
          ch_d       = 1'b0;
          nsamp_d    = 4'd0;
          case (cmd_i.op)
            OpTick: begin
              acc_d   = acc_q + {20'd0, cmd_i.cycles};
              state_d = S_SQ_INIT;
            end
            OpPush:  state_d = S_PUSH;
            OpReg:   state_d = S_EXEC;
            OpRead:  state_d = S_EXEC;
            default: state_d = S_STATUS;
          endcase
        end
      end
      S_EXEC: begin
        state_d = S_STATUS;
        if (cmd_q.op == OpRead) begin
          case (cmd_q.offset)
            RegPsgCtl: rd_d = psg_q;
            RegMixCtl: rd_d = mix_q;
            RegBias:   rd_d = bias_q;
            RegEnable: rd_d = {8'd0, en_q, 3'd0, nz_run_q, 1'b0, sq_run_q[1], sq_run_q[0]};
            default:   rd_d = 16'd0;
          endcase
        end else begin
          case (cmd_q.offset)
            RegPsgCtl: psg_d = v;
            RegMixCtl: begin
              mix_d = v;
              if (v[11]) begin
                level_d[0] = '0;
                cur_d[0]   = 8'd0;
                hold_d[0]  = 1'b0;
                if (!mix_q[11]) begin
                  req_d[0] = 1'b1;
                end
              end
              if (v[15]) begin
                level_d[1] = '0;
                cur_d[1]   = 8'd0;
                hold_d[1]  = 1'b0;
                if (!mix_q[15]) begin
                  req_d[1] = 1'b1;
                end
              end
            end
            RegEnable:  en_d = v[7];
            RegSq0Duty: sq_duty_d[0] = v[7:6];
            RegSq0Vol:  sq_svol_d[0] = v[15:12];
            RegSq1Ctl: begin
              sq_duty_d[1] = v[7:6];
              sq_svol_d[1] = v[15:12];
            end
            RegSq0Freq, RegSq1Freq: begin
              sq_per_d[cmd_q.offset[3]] = 12'd2048 - {1'b0, v[10:0]};
              if (v[15]) begin
                sq_run_d[cmd_q.offset[3]] = 1'b1;
                sq_vol_d[cmd_q.offset[3]] = sq_svol_q[cmd_q.offset[3]];
                sq_tmr_d[cmd_q.offset[3]] = 12'd0;
                sq_ph_d[cmd_q.offset[3]]  = 3'd0;
              end
            end
            RegNzVol: nz_svol_d = v[15:12];
            RegNzCtl: begin
              nz_short_d = v[3];
              nz_per_d   = nz_base << nz_shift;
              if (v[15]) begin
                nz_run_d = 1'b1;
                nz_vol_d = nz_svol_q;
                nz_tmr_d = 23'd0;
                nz_sr_d  = 16'h7FFF;
              end
            end
            RegBias: bias_d = v;
            default: begin
            end
          endcase
        end
      end
      S_PUSH: begin
        if (level_q[cmd_q.fifo] < LW'(FIFO_DEPTH)) begin
          mem_we  = 1'b1;
          lvl_new = level_q[cmd_q.fifo] + LW'(1);
          level_d[cmd_q.fifo] = lvl_new;
        end
        byte_idx_d = byte_idx_q + 2'd1;
        if ({1'b0, byte_idx_q} == cmd_q.nbytes - 3'd1) begin
          if (cmd_q.check && (lvl_new <= LW'(ReqLevel))) begin
            req_d[cmd_q.fifo] = 1'b1;
          end
          state_d = S_STATUS;
        end
      end
      S_SQ_INIT: begin
        if (sq_run_q[ch_q] && (sq_per_q[ch_q] != 12'd0)) begin
          dvd_d   = {1'b0, sq_tmr_q[ch_q]} + {1'b0, cmd_q.cycles};
          rem_d   = 12'd0;
          quo_d   = 3'd0;
          step_d  = 4'd0;
          state_d = S_SQ_DIV;
        end else if (ch_q) begin
          state_d = S_NZ_ADD;
        end else begin
          ch_d = 1'b1;
        end
      end
      S_SQ_DIV: begin
        // Restoring division, one quotient bit per cycle; only the low
        // three quotient bits matter for the phase.
        rem_d  = div_n[11:0];
        dvd_d  = {dvd_q[11:0], 1'b0};
        quo_d  = {quo_q[1:0], div_ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd12) begin
          sq_tmr_d[ch_q] = div_n[11:0];
          sq_ph_d[ch_q]  = sq_ph_q[ch_q] + {quo_q[1:0], div_ge};
          if (ch_q) begin
            state_d = S_NZ_ADD;
          end else begin
            ch_d    = 1'b1;
            state_d = S_SQ_INIT;
          end
        end
      end
      S_NZ_ADD: begin
        ch_d = 1'b0;
        if (nz_run_q && (nz_per_q != 23'd0)) begin
          nz_tmr_d = nz_tmr_q + {11'd0, cmd_q.cycles};
          state_d  = S_NZ_LOOP;
        end else begin
          state_d = S_POP_REQ;
        end
      end
      S_NZ_LOOP: begin
        if (nz_tmr_q >= nz_per_q) begin
          nz_tmr_d = nz_tmr_q - nz_per_q;
          nz_sr_d  = lfsr_step(nz_sr_q, nz_short_q);
        end else begin
          state_d = S_POP_REQ;
        end
      end
      S_POP_REQ: begin
        if (pop_en && (level_q[ch_q] != '0)) begin
          mem_re  = 1'b1;
          state_d = S_POP_DATA;
        end else begin
          if (pop_en) begin
            cur_d[ch_q]  = 8'd0;
            hold_d[ch_q] = 1'b0;
          end
          if (ch_q) begin
            state_d = S_SAMP;
          end else begin
            ch_d = 1'b1;
          end
        end
      end
      S_POP_DATA: begin
        cur_d[ch_q]   = rdata_q;
        hold_d[ch_q]  = 1'b1;
        rptr_d[ch_q]  = (rptr_q[ch_q] == PW'(FIFO_DEPTH - 1)) ? '0
                                                               : rptr_q[ch_q] + PW'(1);
        level_d[ch_q] = level_q[ch_q] - LW'(1);
        if ((level_q[ch_q] - LW'(1)) <= LW'(ReqLevel)) begin
          req_d[ch_q] = 1'b1;
        end
        if (ch_q) begin
          state_d = S_SAMP;
        end else begin
          ch_d    = 1'b1;
          state_d = S_POP_REQ;
        end
      end
      S_SAMP: begin
        if ((acc_q >= 32'(SAMPLE_PERIOD)) && (nsamp_q < 4'(MaxSamples))) begin
          if (emit_ok) begin
            out_valid_d        = 1'b1;
            out_d              = '0;
            out_d.left_sample  = l_sat;
            out_d.right_sample = r_sat;
            out_d.sample_valid = 1'b1;
            acc_d              = acc_q - 32'(SAMPLE_PERIOD);
            nsamp_d            = nsamp_q + 4'd1;
          end
        end else begin
          state_d = S_STATUS;
        end
      end
      S_STATUS: begin
        if (emit_ok) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.read_data     = rd_q;
          out_d.dma_request_a = req_q[0];
          out_d.dma_request_b = req_q[1];
          out_d.last          = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_q       <= rd_d;
    byte_idx_q <= byte_idx_d;
    step_q     <= step_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= 2'b00;
      ch_q        <= 1'b0;
      nsamp_q     <= 4'd0;
      hold_q      <= 2'b00;
      psg_q       <= 16'd0;
      mix_q       <= 16'd0;
      bias_q      <= 16'd0;
      en_q        <= 1'b0;
      sq_run_q    <= 2'b00;
      nz_svol_q   <= 4'd0;
      nz_vol_q    <= 4'd0;
      nz_run_q    <= 1'b0;
      nz_short_q  <= 1'b0;
      nz_per_q    <= 23'd0;
      nz_tmr_q    <= 23'd0;
      nz_sr_q     <= 16'h7FFF;
      acc_q       <= 32'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        level_q[i]   <= '0;
        rptr_q[i]    <= '0;
        cur_q[i]     <= 8'd0;
        sq_duty_q[i] <= 2'd0;
        sq_per_q[i]  <= 12'd2048;
        sq_tmr_q[i]  <= 12'd0;
        sq_ph_q[i]   <= 3'd0;
        sq_svol_q[i] <= 4'd0;
        sq_vol_q[i]  <= 4'd0;
      end
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      ch_q        <= ch_d;
      nsamp_q     <= nsamp_d;
      hold_q      <= hold_d;
      psg_q       <= psg_d;
      mix_q       <= mix_d;
      bias_q      <= bias_d;
      en_q        <= en_d;
      sq_run_q    <= sq_run_d;
      nz_svol_q   <= nz_svol_d;
      nz_vol_q    <= nz_vol_d;
      nz_run_q    <= nz_run_d;
      nz_short_q  <= nz_short_d;
      nz_per_q    <= nz_per_d;
      nz_tmr_q    <= nz_tmr_d;
      nz_sr_q     <= nz_sr_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      level_q     <= level_d;
      rptr_q      <= rptr_d;
      cur_q       <= cur_d;
      sq_duty_q   <= sq_duty_d;
      sq_per_q    <= sq_per_d;
      sq_tmr_q    <= sq_tmr_d;
      sq_ph_q     <= sq_ph_d;
      sq_svol_q   <= sq_svol_d;
      sq_vol_q    <= sq_vol_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/sfpm_checker.sv
`include "sound_fifo_psg_mixer_top_defines.svh"

module sfpm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sfpm_pkg::sfpm_out_t out_data_o
);
  import sfpm_pkg::*;

  logic out_held;
  logic sample_out;
  logic status_out;

  assign out_held   = out_valid_o && out_stall_i;
  assign sample_out = out_valid_o && out_data_o.sample_valid;
  assign status_out = out_valid_o && out_data_o.last;

  `SFPM_ASSERT_NXT(a_out_valid_held, out_held, out_valid_o, "result dropped while stalled")
  `SFPM_ASSERT_NXT(a_out_data_held, out_held, $stable(out_data_o), "stalled result changed")
  `SFPM_ASSERT_IMP(a_sample_clean, sample_out, !out_data_o.last && out_data_o.read_data == 16'd0 && !out_data_o.dma_request_a && !out_data_o.dma_request_b, "sample result carries status fields")
  `SFPM_ASSERT_IMP(a_status_clean, status_out, !out_data_o.sample_valid && out_data_o.left_sample == 16'sd0 && out_data_o.right_sample == 16'sd0, "status result carries sample data")

endmodule

bind sound_fifo_psg_mixer_top sfpm_checker u_sfpm_checker (.*);

### sim/tb.sv
module tb;
  import sfpm_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  // The wave of each duty code, indexed by phase.
  localparam logic [7:0] DutyWave [4] = '{8'b1000_0000, 8'b1000_0001,
                                          8'b1110_0001, 8'b0111_1110};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sfpm_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sfpm_out_t out_data;

  sound_fifo_psg_mixer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #2 clk_i = ~clk_i;

  sfpm_in_t  pending_items[$];
  sfpm_out_t expected_results[$];
  int unsigned errors = 0, samples_seen = 0, items_sent = 0, cycle_count = 0;
  bit run_done = 1'b0;

  // Mirror of the sound unit state.
  logic [7:0]  pcm_fifo[2][$];
  int          pcm_current[2];
  bit          pcm_holding[2];
  logic [15:0] psg_ctl, mix_ctl, bias_reg;
  bit          enable_bit;
  int unsigned sq_duty[2], sq_len[2], sq_timer[2], sq_phase[2];
  int unsigned sq_start_vol[2], sq_vol[2];
  bit          sq_on[2];
  int unsigned nz_start_vol, nz_vol, nz_period, nz_timer, nz_lfsr;
  bit          nz_on, nz_short;
  int unsigned acc_cycles;
  bit          refill[2];

  function automatic void reset_mirror();
    for (int i = 0; i < 2; i++) begin
      pcm_fifo[i].delete();
      pcm_current[i] = 0;
      pcm_holding[i] = 0;
      sq_duty[i] = 0; sq_len[i] = 2048; sq_timer[i] = 0; sq_phase[i] = 0;
      sq_start_vol[i] = 0; sq_vol[i] = 0; sq_on[i] = 0;
    end
    psg_ctl = '0; mix_ctl = '0; bias_reg = '0; enable_bit = 0;
    nz_start_vol = 0; nz_vol = 0; nz_period = 0; nz_timer = 0; nz_lfsr = 'h7FFF;
    nz_on = 0; nz_short = 0; acc_cycles = 0;
  endfunction

  function automatic void append_pcm(int f, logic [7:0] b);
    if (pcm_fifo[f].size() < FifoDepthDef) pcm_fifo[f].push_back(b);
  endfunction

  function automatic void note_level(int f);
    if (pcm_fifo[f].size() <= ReqLevel) refill[f] = 1;
  endfunction

  function automatic void clear_pcm(int f);
    pcm_fifo[f].delete();
    pcm_current[f] = 0;
    pcm_holding[f] = 0;
  endfunction

  function automatic void pop_pcm(int f);
    logic [7:0] b;
    if (pcm_fifo[f].size() == 0) begin
      clear_pcm(f);
      return;
    end
    b = pcm_fifo[f].pop_front();
    pcm_current[f] = $signed(b);
    pcm_holding[f] = 1;
    note_level(f);
  endfunction

  function automatic void write_register(logic [7:0] off, logic [15:0] v);
    logic [15:0] old;
    int unsigned shift;
    int i;
    old = mix_ctl;
    case (off)
      RegPsgCtl: psg_ctl = v;
      RegMixCtl: begin
        mix_ctl = v;
        if (v[11]) clear_pcm(0);
        if (v[15]) clear_pcm(1);
        if (!old[11] && v[11]) note_level(0);
        if (!old[15] && v[15]) note_level(1);
      end
      RegEnable: enable_bit = v[7];
      RegSq0Duty: sq_duty[0] = v[7:6];
      RegSq0Vol: sq_start_vol[0] = v[15:12];
      RegSq1Ctl: begin
        sq_duty[1] = v[7:6];
        sq_start_vol[1] = v[15:12];
      end
      RegSq0Freq, RegSq1Freq: begin
        i = (off == RegSq0Freq) ? 0 : 1;
        sq_len[i] = 2048 - v[10:0];
        if (v[15]) begin
          sq_on[i] = 1; sq_vol[i] = sq_start_vol[i]; sq_timer[i] = 0; sq_phase[i] = 0;
        end
      end
      RegNzVol: nz_start_vol = v[15:12];
      RegNzCtl: begin
        shift = v[7:4];
        if (shift > 14) shift = 14;
        nz_short = v[3];
        nz_period = (32 * (v[2:0] + 1)) << shift;
        if (v[15]) begin
          nz_on = 1; nz_vol = nz_start_vol; nz_timer = 0; nz_lfsr = 'h7FFF;
        end
      end
      RegBias: bias_reg = v;
      default: begin
        if (off >= RegFifoLo && off <= RegFifoHi) begin
          i = off[2];
          append_pcm(i, v[7:0]);
          append_pcm(i, v[15:8]);
          note_level(i);
        end
      end
    endcase
  endfunction

  function automatic logic [15:0] read_register(logic [7:0] off);
    case (off)
      RegPsgCtl: return psg_ctl;
      RegMixCtl: return mix_ctl;
      RegBias: return bias_reg;
      RegEnable: return {8'h00, enable_bit, 3'b000, nz_on, 1'b0, sq_on[1], sq_on[0]};
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp16(int x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic sfpm_out_t mixed_sample();
    sfpm_out_t o;
    int l, r, pl, pr, s;
    l = 0; r = 0; pl = 0; pr = 0;
    if (enable_bit) begin
      for (int i = 0; i < 2; i++) begin
        if (sq_on[i] && DutyWave[sq_duty[i]][sq_phase[i]]) begin
          if (psg_ctl[8 + i]) pr += sq_vol[i];
          if (psg_ctl[12 + i]) pl += sq_vol[i];
        end
      end
      if (nz_on && !nz_lfsr[0]) begin
        if (psg_ctl[11]) pr += nz_vol;
        if (psg_ctl[15]) pl += nz_vol;
      end
      pl = (pl * (psg_ctl[6:4] + 1)) / 8;
      pr = (pr * (psg_ctl[2:0] + 1)) / 8;
      if (mix_ctl[1:0] == 2'd0) begin
        pl /= 4; pr /= 4;
      end else if (mix_ctl[1:0] == 2'd1) begin
        pl /= 2; pr /= 2;
      end
      l = pl * 1024;
      r = pr * 1024;
    end
    for (int i = 0; i < 2; i++) begin
      s = pcm_holding[i] ? pcm_current[i] : 0;
      s = mix_ctl[i ? 3 : 2] ? s * 256 : s * 128;
      if (mix_ctl[i ? 12 : 8]) r += s;
      if (mix_ctl[i ? 13 : 9]) l += s;
    end
    o = '0;
    o.left_sample = clamp16(l);
    o.right_sample = clamp16(r);
    o.sample_valid = 1'b1;
    return o;
  endfunction

  function automatic void advance_time(int unsigned cyc, logic [1:0] ovf);
    int unsigned x;
    int n;
    for (int i = 0; i < 2; i++) begin
      if (!sq_on[i] || sq_len[i] == 0) continue;
      sq_timer[i] += cyc;
      sq_phase[i] = (sq_phase[i] + sq_timer[i] / sq_len[i]) & 7;
      sq_timer[i] %= sq_len[i];
    end
    if (nz_on && nz_period > 0) begin
      nz_timer += cyc;
      while (nz_timer >= nz_period) begin
        nz_timer -= nz_period;
        x = (nz_lfsr ^ (nz_lfsr >> 1)) & 1;
        nz_lfsr = ((nz_lfsr >> 1) | (x << 14)) & 'h7FFF;
        if (nz_short) nz_lfsr = (nz_lfsr & ~32'h40) | (x << 6);
      end
    end
    for (int t = 0; t < 2; t++) begin
      if (!ovf[t]) continue;
      for (int i = 0; i < 2; i++)
        if (mix_ctl[i ? 14 : 10] == t) pop_pcm(i);
    end
    acc_cycles += cyc;
    n = 0;
    while (acc_cycles >= SamplePeriodDef && n < MaxSamples) begin
      acc_cycles -= SamplePeriodDef;
      expected_results.push_back(mixed_sample());
      n++;
    end
  endfunction

  function automatic void predict_item(sfpm_in_t it);
    sfpm_out_t st;
    st = '0;
    refill[0] = 0;
    refill[1] = 0;
    case (it.mode)
      ModeTick: advance_time(it.cycles, it.timer_overflow);
      ModeByteWr: begin
        if (it.offset >= RegFifoLo && it.offset <= RegFifoHi) begin
          append_pcm(it.offset[2], it.write_data[7:0]);
          note_level(it.offset[2]);
        end
      end
      ModeHalfWr: write_register(it.offset, it.write_data[15:0]);
      ModeHalfRd: st.read_data = read_register(it.offset);
      ModeDmaWord:
        for (int k = 0; k < 4; k++) append_pcm(it.fifo_select, it.write_data[8*k +: 8]);
      default: ;
    endcase
    st.dma_request_a = refill[0];
    st.dma_request_b = refill[1];
    st.last = 1'b1;
    expected_results.push_back(st);
  endfunction

  function automatic void queue_item(logic [2:0] mode, logic [7:0] off, logic [31:0] data,
                                     logic fsel, logic [11:0] cyc, logic [1:0] ovf);
    sfpm_in_t it;
    it.mode = mode; it.offset = off; it.write_data = data;
    it.fifo_select = fsel; it.cycles = cyc; it.timer_overflow = ovf;
    pending_items.push_back(it);
  endfunction

  // Driver: holds each item until its transfer, then waits a drawn gap, or none during a burst.
  int unsigned in_gap = 0, in_burst = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        items_sent++;
        if (in_burst > 0) begin
          in_burst--;
          in_gap = 0;
        end else begin
          in_gap = $urandom_range(0, 15);
          if ($urandom_range(0, 19) == 0) in_burst = $urandom_range(10, 40);
        end
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || pending_items.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks every result transfer against the oldest expectation.
  int unsigned out_hold = 0, out_burst = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    sfpm_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %p", out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.sample_valid) samples_seen++;
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
            errors++;
          end
          if (out_data.left_sample !== want.left_sample) begin
            $error("left_sample: expected %0d, got %0d", want.left_sample,
                   out_data.left_sample);
            errors++;
          end
          if (out_data.right_sample !== want.right_sample) begin
            $error("right_sample: expected %0d, got %0d", want.right_sample,
                   out_data.right_sample);
            errors++;
          end
          if (out_data.sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %b, got %b", want.sample_valid,
                   out_data.sample_valid);
            errors++;
          end
          if (out_data.dma_request_a !== want.dma_request_a) begin
            $error("dma_request_a: expected %b, got %b", want.dma_request_a,
                   out_data.dma_request_a);
            errors++;
          end
          if (out_data.dma_request_b !== want.dma_request_b) begin
            $error("dma_request_b: expected %b, got %b", want.dma_request_b,
                   out_data.dma_request_b);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            errors++;
          end
        end
        if (out_burst > 0) begin
          out_burst--;
          out_hold = 0;
        end else begin
          out_hold = $urandom_range(0, 15);
          if ($urandom_range(0, 19) == 0) out_burst = $urandom_range(10, 40);
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit && !run_done) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [7:0] regs [11];
    logic [7:0] off;
    logic [31:0] data;
    int unsigned pick;
    regs = '{RegSq0Duty, RegSq0Vol, RegSq0Freq, RegSq1Ctl, RegSq1Freq, RegNzVol,
             RegNzCtl, RegPsgCtl, RegMixCtl, RegEnable, RegBias};
    reset_mirror();

    // Directed part: reset values, full setup, extremes and corner cases.
    queue_item(ModeHalfRd, RegEnable, '0, 1'b0, '0, '0);
    queue_item(ModeTick, 8'h00, '0, 1'b0, 12'hFFF, 2'b11);  // pops from empty FIFOs
    queue_item(ModeHalfWr, RegEnable, 32'hFFFF_0080, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegPsgCtl, 32'h0000_FF77, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegMixCtl, 32'h0000_770E, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegSq0Duty, 32'h0000_00C0, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegSq0Vol, 32'h0000_F000, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegSq0Freq, 32'h0000_87FF, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegSq1Ctl, 32'h0000_F080, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegSq1Freq, 32'h0000_8000, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegNzVol, 32'h0000_F000, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegNzCtl, 32'h0000_80F8, 1'b0, '0, '0);  // shift 15 acts as 14
    queue_item(ModeHalfWr, RegNzCtl, 32'h0000_8000, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegBias, 32'h0000_FFFF, 1'b0, '0, '0);
    for (int k = 0; k < 9; k++)  // overfills FIFO A
      queue_item(ModeDmaWord, 8'h00, 32'h80FF_7F01, 1'b0, '0, '0);
    queue_item(ModeHalfWr, 8'hAC, 32'h0000_7F80, 1'b0, '0, '0);
    queue_item(ModeByteWr, 8'hA5, 32'hFFFF_FF80, 1'b1, '0, '0);
    queue_item(ModeByteWr, RegPsgCtl, 32'h0000_00FF, 1'b0, '0, '0);  // ignored outside FIFO window
    queue_item(ModeTick, 8'hFF, '0, 1'b1, 12'hFFF, 2'b01);
    queue_item(ModeTick, 8'h00, '0, 1'b0, 12'hFFF, 2'b10);
    queue_item(ModeHalfRd, 8'h8A, '0, 1'b0, '0, '0);
    queue_item(3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b1, 12'hFFF, 2'b11);
    queue_item(3'd5, 8'h00, '0, 1'b0, '0, '0);
    queue_item(ModeHalfWr, RegMixCtl, 32'h0000_8800, 1'b0, '0, '0);

    // Random part: mostly playback sequences of appends and ticks.
    for (int n = 0; n < 238; n++) begin
      pick = $urandom_range(0, 99);
      data = $urandom();
      if (pick < 30) begin
        queue_item(ModeTick, 8'($urandom()), data, 1'($urandom()),
                   ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                               : 12'($urandom_range(0, 1100)),
                   2'($urandom()));
      end else if (pick < 45) begin
        queue_item(ModeDmaWord, 8'($urandom()), data, 1'($urandom()), 12'($urandom()),
                   2'($urandom()));
      end else if (pick < 55) begin
        queue_item(ModeHalfWr, 8'hA0 + 8'($urandom_range(0, 15)), data, 1'b0, '0, '0);
      end else if (pick < 75) begin
        off = regs[$urandom_range(0, 10)];
        // Keep the FIFO reset bits mostly clear so data gets played.
        if (off == RegMixCtl && $urandom_range(0, 3) != 0) data[15] = 1'b0;
        if (off == RegMixCtl && $urandom_range(0, 3) != 0) data[11] = 1'b0;
        queue_item(ModeHalfWr, off, data, 1'($urandom()), 12'($urandom()), 2'($urandom()));
      end else if (pick < 87) begin
        off = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : regs[$urandom_range(7, 10)];
        queue_item(ModeHalfRd, off, data, 1'($urandom()), 12'($urandom()), 2'($urandom()));
      end else if (pick < 94) begin
        off = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                          : 8'hA0 + 8'($urandom_range(0, 15));
        queue_item(ModeByteWr, off, data, 1'($urandom()), 12'($urandom()), 2'($urandom()));
      end else begin
        queue_item(3'($urandom_range(1, 7)), 8'($urandom()), data, 1'($urandom()),
                   12'($urandom()), 2'($urandom()));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    run_done = 1'b1;
    $display("%0d items sent, %0d samples checked, %0d mismatches", items_sent,
             samples_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
